/* rtl/core/utf8d_pkg.sv */
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Transfer types and status codes shared by the decoder modules.
// ----------------------------------------------------------------------------
package utf8d_pkg;

    localparam int CpWidth  = 21;
    localparam int CntWidth = 3;
    localparam int StWidth  = 2;

    localparam logic [StWidth-1:0] ST_OK         = 2'd0;
    localparam logic [StWidth-1:0] ST_INVALID    = 2'd1;
    localparam logic [StWidth-1:0] ST_INCOMPLETE = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_buffer;
    } t_in_item;

    typedef struct packed {
        logic [CpWidth-1:0]  code_point;
        logic [CntWidth-1:0] byte_count;
        logic [StWidth-1:0]  status;
    } t_out_item;

endpackage

/* rtl/core/utf8d_core.sv */
// ----------------------------------------------------------------------------
// UTF-8 decoder core
// Holds the partial code point and applies one byte per step.
// ----------------------------------------------------------------------------
module utf8d_core
    import utf8d_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    output logic      o_res_valid,
    output t_out_item o_res
);

    logic [1:0]          r_pending;
    logic [CpWidth-1:0]  r_partial;
    logic [CntWidth-1:0] r_seq_len;
    logic [1:0]          n_pending;
    logic [CpWidth-1:0]  n_partial;
    logic [CntWidth-1:0] n_seq_len;
    logic [CpWidth-1:0]  shifted;
    logic [1:0]          pend_dec;
    logic [7:0]          b;

    assign b        = i_item.in_byte;
    assign shifted  = {r_partial[CpWidth-7:0], b[5:0]};
    assign pend_dec = r_pending - 2'd1;

    always_comb begin
        n_pending   = r_pending;
        n_partial   = r_partial;
        n_seq_len   = r_seq_len;
        o_res_valid = 1'b0;
        o_res       = '{code_point: '0, byte_count: '0, status: ST_OK};
        if (r_pending == 2'd0) begin
            case (b) inside
                8'h00: begin
                    o_res_valid = 1'b1;
                end
                [8'h01:8'h7F]: begin
                    o_res_valid      = 1'b1;
                    o_res.code_point = CpWidth'(b);
                    o_res.byte_count = CntWidth'(1);
                end
                [8'hC0:8'hDF]: begin
                    n_partial = CpWidth'(b[4:0]);
                    n_pending = 2'd1;
                    n_seq_len = CntWidth'(2);
                end
                [8'hE0:8'hEF]: begin
                    n_partial = CpWidth'(b[3:0]);
                    n_pending = 2'd2;
                    n_seq_len = CntWidth'(3);
                end
                [8'hF0:8'hF7]: begin
                    n_partial = CpWidth'(b[2:0]);
                    n_pending = 2'd3;
                    n_seq_len = CntWidth'(4);
                end
                default: begin
                    // Stray continuation byte or a lead of 0xF8 and above.
                    o_res_valid  = 1'b1;
                    o_res.status = ST_INVALID;
                end
            endcase
            // A multi-byte lead on the last available byte cannot finish.
            if (b[7:6] == 2'b11 && b < 8'hF8 && i_item.end_of_buffer) begin
                n_pending    = 2'd0;
                n_partial    = '0;
                n_seq_len    = '0;
                o_res_valid  = 1'b1;
                o_res.status = ST_INCOMPLETE;
            end
        end else begin
            n_partial = shifted;
            n_pending = pend_dec;
            if (pend_dec == 2'd0) begin
                o_res_valid      = 1'b1;
                o_res.code_point = shifted;
                o_res.byte_count = r_seq_len;
                n_partial        = '0;
                n_seq_len        = '0;
            end else if (i_item.end_of_buffer) begin
                o_res_valid  = 1'b1;
                o_res.status = ST_INCOMPLETE;
                n_pending    = 2'd0;
                n_partial    = '0;
                n_seq_len    = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 2'd0;
            r_partial <= '0;
            r_seq_len <= '0;
        end else if (i_step) begin
            r_pending <= n_pending;
            r_partial <= n_partial;
            r_seq_len <= n_seq_len;
        end
    end

endmodule

/* rtl/core/utf8_stream_decoder_top.sv */
// ----------------------------------------------------------------------------
// UTF-8 stream decoder
// Decodes a byte stream into code points, one byte per transfer.
// ----------------------------------------------------------------------------
//   channel | direction | payload    | handshake
//   in      | input     | t_in_item  | i_in_valid / o_in_ready
//   out     | output    | t_out_item | o_out_valid / i_out_ready
//
// One byte is taken every cycle unless a byte that gives a result waits on a stalled output.
// The byte register feeds the decode logic, whose result lands in the output
// register. A byte that gives no result moves on even while the output stalls.
// Reset clears the decoder state and both valid flags.
module utf8_stream_decoder_top
    import utf8d_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic      r_s1_valid;
    t_in_item  r_s1_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      res_valid;
    t_out_item res;
    logic      out_free;
    logic      s1_step;

    assign out_free    = !r_out_valid || i_out_ready;
    assign s1_step     = r_s1_valid && (out_free || !res_valid);
    assign o_in_ready  = !r_s1_valid || s1_step;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    utf8d_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (s1_step),
        .i_item     (r_s1_item),
        .o_res_valid(res_valid),
        .o_res      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= s1_step && res_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1_item <= i_in_item;
        end
        if (out_free && s1_step && res_valid) begin
            r_out_item <= res;
        end
    end

`ifndef SYNTHESIS
    // Error results never carry a value or a length.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != ST_OK |->
            o_out_item.code_point == '0 && o_out_item.byte_count == '0)
        else $error("error result with nonzero payload");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.status == ST_OK ||
            o_out_item.status == ST_INVALID || o_out_item.status == ST_INCOMPLETE)
        else $error("undefined status code");

    a_ascii_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.byte_count == 3'd1 |-> o_out_item.code_point < 21'd128)
        else $error("single-byte result out of range");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled while output register is empty");
`endif

endmodule
